@@ rtl/phf_pkg.sv @@
package phf_pkg;

   localparam int TABLE_ENTRIES = 511;
   localparam int BUCKET_W      = 9;
   localparam int SLOTS         = 8;
   localparam int SLOT_W        = 3;
   localparam int ACC_W         = 32;
   localparam int CH_W          = 16;
   localparam int FOLD_W        = BUCKET_W + 2;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_PTR_W   = 2;

   typedef enum logic [1:0] {
      FUNC_CLEAR   = 2'd0,
      FUNC_DISABLE = 2'd1,
      FUNC_INSERT  = 2'd2,
      FUNC_LOOKUP  = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]        func;
      logic [CH_W-1:0]   ch;
      logic              last;
      logic [SLOT_W-1:0] dir_slot;
   } req_type;

   typedef struct packed {
      logic [BUCKET_W-1:0] bucket;
      logic [SLOTS-1:0]    candidate_mask;
      logic                enabled;
   } rsp_type;

   typedef struct packed {
      func_type          kind;
      logic [ACC_W-1:0]  acc;
      logic [SLOT_W-1:0] slot;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_FOLD,
      BK_BUCKET,
      BK_READ
   } back_state_type;

endpackage

@@ rtl/phf_ram.sv @@
module phf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 511
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/phf_front.sv @@
module phf_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  phf_pkg::req_type req_data,
   input  logic            table_ready,
   output logic            push_valid,
   input  logic            push_ready,
   output phf_pkg::cmd_type push_data
);
   import phf_pkg::*;

   logic [ACC_W-1:0] acc_ff;
   logic [ACC_W-1:0] acc_in;
   logic [ACC_W-1:0] acc_sum;
   logic             accept;
   logic             is_cmd;

   assign req_ready = push_ready && table_ready;
   assign accept    = req_valid && req_ready;
   assign is_cmd    = (req_data.func == FUNC_CLEAR) || (req_data.func == FUNC_DISABLE);
   assign acc_sum   = {acc_ff[ACC_W-2:0], 1'b0} + ACC_W'(req_data.ch);

   always_comb begin
      acc_in = acc_ff;
      if (accept) begin
         if (is_cmd || req_data.last) begin
            acc_in = '0;
         end else begin
            acc_in = acc_sum;
         end
      end
   end

   assign push_valid     = accept && (is_cmd || req_data.last);
   assign push_data.kind = func_type'(req_data.func);
   assign push_data.acc  = acc_sum;
   assign push_data.slot = req_data.dir_slot;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

endmodule

@@ rtl/phf_queue.sv @@
module phf_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  phf_pkg::cmd_type push_data,
   output logic             pop_valid,
   input  logic             pop,
   output phf_pkg::cmd_type pop_data
);
   import phf_pkg::*;

   cmd_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0] wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0] rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff;
   logic [QUEUE_PTR_W:0]   count_in;
   logic                   do_push;
   logic                   do_pop;

   assign push_ready = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/phf_back.sv @@
module phf_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  phf_pkg::cmd_type cmd_data,
   output logic             table_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output phf_pkg::rsp_type rsp_data
);
   import phf_pkg::*;

   back_state_type      state_ff;
   back_state_type      state_in;
   logic [BUCKET_W-1:0] clr_cnt_ff;
   logic [BUCKET_W-1:0] clr_cnt_in;
   logic                init_ff;
   logic                init_in;
   logic                enabled_ff;
   logic                enabled_in;
   func_type            kind_ff;
   func_type            kind_in;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   slot_in;
   logic [ACC_W-1:0]    mag_ff;
   logic [ACC_W-1:0]    mag_in;
   logic [FOLD_W-1:0]   fold_ff;
   logic [FOLD_W-1:0]   fold_in;
   logic [BUCKET_W-1:0] bucket_ff;
   logic [BUCKET_W-1:0] bucket_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   rsp_type             rsp_data_ff;
   rsp_type             rsp_data_in;

   logic                clr_last;
   logic                rsp_free;
   logic                rsp_load;
   logic [BUCKET_W:0]   fold2;
   logic [BUCKET_W-1:0] bucket_calc;
   logic                ram_we;
   logic [BUCKET_W-1:0] ram_waddr;
   logic [SLOTS-1:0]    ram_wdata;
   logic                ram_re;
   logic [SLOTS-1:0]    ram_rdata;

   assign clr_last = (clr_cnt_ff == BUCKET_W'(TABLE_ENTRIES - 1));
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Since 2^BUCKET_W is one above the table size, each BUCKET_W-bit digit
   // of the magnitude adds in with weight one.
   assign fold2 = (BUCKET_W+1)'(fold_ff[BUCKET_W-1:0])
                + (BUCKET_W+1)'(fold_ff[FOLD_W-1:BUCKET_W]);
   assign bucket_calc = (fold2 >= (BUCKET_W+1)'(TABLE_ENTRIES))
                      ? BUCKET_W'(fold2 - (BUCKET_W+1)'(TABLE_ENTRIES))
                      : BUCKET_W'(fold2);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_last) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd_data.kind)
                  FUNC_CLEAR:   state_in = BK_CLEAR;
                  FUNC_INSERT:  state_in = BK_FOLD;
                  FUNC_LOOKUP:  state_in = BK_FOLD;
                  default:      state_in = BK_IDLE;
               endcase
            end
         end
         BK_FOLD:   state_in = BK_BUCKET;
         BK_BUCKET: state_in = BK_READ;
         BK_READ: begin
            if (kind_ff == FUNC_INSERT || rsp_free) begin
               state_in = BK_IDLE;
            end
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      cmd_pop   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = bucket_ff;
      ram_wdata = ram_rdata | (SLOTS'(1) << slot_ff);
      ram_re    = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_ff;
            ram_wdata = '0;
         end
         BK_IDLE: begin
            cmd_pop = cmd_valid;
         end
         BK_BUCKET: begin
            ram_re = 1'b1;
         end
         BK_READ: begin
            ram_we   = (kind_ff == FUNC_INSERT);
            rsp_load = (kind_ff == FUNC_LOOKUP) && rsp_free;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      clr_cnt_in = '0;
      if (state_ff == BK_CLEAR && !clr_last) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      init_in = init_ff && !(state_ff == BK_CLEAR && clr_last);

      enabled_in = enabled_ff;
      kind_in    = kind_ff;
      slot_in    = slot_ff;
      mag_in     = mag_ff;
      if (cmd_pop) begin
         kind_in = cmd_data.kind;
         slot_in = cmd_data.slot;
         mag_in  = cmd_data.acc[ACC_W-1] ? (~cmd_data.acc + 1'b1) : cmd_data.acc;
         if (cmd_data.kind == FUNC_CLEAR) begin
            enabled_in = 1'b1;
         end else if (cmd_data.kind == FUNC_DISABLE) begin
            enabled_in = 1'b0;
         end
      end

      fold_in = FOLD_W'(mag_ff[BUCKET_W-1:0])
              + FOLD_W'(mag_ff[2*BUCKET_W-1:BUCKET_W])
              + FOLD_W'(mag_ff[3*BUCKET_W-1:2*BUCKET_W])
              + FOLD_W'(mag_ff[ACC_W-1:3*BUCKET_W]);
      bucket_in = (state_ff == BK_BUCKET) ? bucket_calc : bucket_ff;

      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.bucket         = bucket_ff;
         rsp_data_in.candidate_mask = ram_rdata;
         rsp_data_in.enabled        = enabled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_cnt_ff   <= '0;
         init_ff      <= 1'b1;
         enabled_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         init_ff      <= init_in;
         enabled_ff   <= enabled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      slot_ff     <= slot_in;
      mag_ff      <= mag_in;
      fold_ff     <= fold_in;
      bucket_ff   <= bucket_in;
      rsp_data_ff <= rsp_data_in;
   end

   phf_ram #(
      .WIDTH (SLOTS),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (bucket_calc),
      .rdata (ram_rdata)
   );

   assign table_ready = !init_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;

endmodule

@@ rtl/path_name_hash_filter.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_data: func, ch, last, dir_slot
// rsp_      out        rsp_valid / rsp_ready  rsp_data: bucket, candidate_mask, enabled
//
// A character that does not end a name is only added into the front accumulator.
// A final insert or lookup passes the back steps pop, fold, reduce and read, then write or respond.
// A disable is handled at the pop, and a clear is popped and then sweeps all 511 table entries.
// After reset the same table sweep runs, and req_ready stays low until it ends.
// A four-item queue lets the front keep taking items while the back works or
// while a result waits on rsp_ready.
module path_name_hash_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  phf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output phf_pkg::rsp_type rsp_data
);
   import phf_pkg::*;

   logic    table_ready;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_data;
   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd_data;

   phf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .table_ready (table_ready),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_data   (push_data)
   );

   phf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (cmd_valid),
      .pop        (cmd_pop),
      .pop_data   (cmd_data)
   );

   phf_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_pop     (cmd_pop),
      .cmd_data    (cmd_data),
      .table_ready (table_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

@@ rtl/phf_checker.sv @@
module phf_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input phf_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input phf_pkg::rsp_type rsp_data
);
   import phf_pkg::*;

   // The table sweep after reset holds off new items.
   assert property (@(posedge clock) reset |=> !req_ready)
      else $error("item accepted during the table sweep after reset");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_ready) |=> (req_valid && $stable(req_data)))
      else $error("waiting item changed before it was taken");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.bucket < BUCKET_W'(TABLE_ENTRIES)))
      else $error("bucket outside the table");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind path_name_hash_filter phf_checker u_phf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
